FILE: rtl/cfbv_pkg.sv
// Shared constants and types for the framed blob CRC-32 validator.
`default_nettype none
package cfbv_pkg;

    localparam int ITEM_BYTES   = 20;
    localparam int HEADER_BYTES = 8;
    localparam int TAIL_BYTES   = 4;
    localparam int MIN_BYTES    = HEADER_BYTES + TAIL_BYTES;

    localparam int CNT_W   = 17;
    localparam int COUNT_W = 16;
    localparam int EXP_W   = COUNT_W + $clog2(ITEM_BYTES + 1) + 1;
    localparam int CFG_W   = 32;
    localparam int OUT_W   = 24;

    localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [31:0]      CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0]      CRC_POLY = 32'hEDB8_8320;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_CORRUPT = 2'd2,
        ST_CRC     = 2'd3
    } t_status;

    typedef enum logic [0:0] {
        REG_MAGIC   = 1'd0,
        REG_VERSION = 1'd1
    } t_reg_idx;

    typedef struct packed {
        t_status              status;
        logic [COUNT_W-1:0]   entry_count;
    } t_result;

endpackage
`default_nettype wire

FILE: rtl/cfbv_crc_step.sv
// One byte of reflected CRC-32, unrolled into XOR logic.
`default_nettype none
module cfbv_crc_step
    import cfbv_pkg::*;
(
    input  wire logic [31:0] i_crc,
    input  wire logic [7:0]  i_byte,
    output logic      [31:0] o_crc
);

    always_comb begin
        logic [31:0] c;
        c = i_crc ^ {24'd0, i_byte};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        o_crc = c;
    end

endmodule
`default_nettype wire

FILE: rtl/cfbv_frame_chk.sv
// Per-blob stream state: byte counter, header capture, tail window, CRC and final checks.
`default_nettype none
module cfbv_frame_chk
    import cfbv_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic [7:0]         i_byte,
    input  wire logic               i_last,
    input  wire logic [31:0]        i_magic,
    input  wire logic [15:0]        i_version,
    output t_result                 o_result
);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [31:0]      r_crc, n_crc, w_crc_fed;
    logic [31:0]      r_tail, n_tail;
    logic [63:0]      r_hdr, n_hdr;
    logic [EXP_W-1:0] w_expected;
    logic             w_len_bad;

    cfbv_crc_step u_crc (
        .i_crc  (r_crc),
        .i_byte (r_tail[7:0]),
        .o_crc  (w_crc_fed)
    );

    always_comb begin
        n_hdr = r_hdr;
        for (int i = 0; i < HEADER_BYTES; i++) begin
            if (r_cnt == CNT_W'(i)) begin
                n_hdr[8*i +: 8] = i_byte;
            end
        end
        n_crc  = (r_cnt >= CNT_W'(TAIL_BYTES)) ? w_crc_fed : r_crc;
        n_tail = {i_byte, r_tail[31:8]};
        n_cnt  = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + 1'b1;

        w_expected = EXP_W'(MIN_BYTES) + EXP_W'(n_hdr[63:48]) * EXP_W'(ITEM_BYTES);
        w_len_bad  = (n_cnt == CNT_MAX) || (EXP_W'(n_cnt) != w_expected);

        o_result.entry_count = n_hdr[63:48];
        if (n_cnt < CNT_W'(MIN_BYTES)) begin
            o_result.status = ST_SHORT;
        end else if (n_hdr[31:0] != i_magic) begin
            o_result.status = ST_CORRUPT;
        end else if (n_hdr[47:32] != i_version) begin
            o_result.status = ST_CORRUPT;
        end else if (w_len_bad) begin
            o_result.status = ST_CORRUPT;
        end else if ((n_crc ^ CRC_INIT) != n_tail) begin
            o_result.status = ST_CRC;
        end else begin
            o_result.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_crc  <= CRC_INIT;
            r_tail <= '0;
            r_hdr  <= '0;
        end else if (i_en) begin
            if (i_last) begin
                r_cnt  <= '0;
                r_crc  <= CRC_INIT;
                r_tail <= '0;
                r_hdr  <= '0;
            end else begin
                r_cnt  <= n_cnt;
                r_crc  <= n_crc;
                r_tail <= n_tail;
                r_hdr  <= n_hdr;
            end
        end
    end

`ifndef SYNTHESIS
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_last) |=> (r_cnt == '0 && r_hdr == '0 && r_tail == '0))
        else $error("stream state not cleared after last byte");

    a_crc_idle_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt < CNT_W'(TAIL_BYTES)) |-> (r_crc == CRC_INIT))
        else $error("crc advanced before tail window filled");

    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> ($stable(r_cnt) && $stable(r_crc) && $stable(r_tail)))
        else $error("stream state moved without an item");
`endif

endmodule
`default_nettype wire

FILE: rtl/crc32_framed_blob_validator_core.sv
// Top level: input register, blob checker, result register and config registers.
//
//  channel | dir | handshake              | payload
//  s       | in  | i_s_tvalid/o_s_tready  | i_s_tdata = data_byte, i_s_tlast = is_last
//  m       | out | o_m_tvalid/i_m_tready  | o_m_tdata = status, entry_count
//  cfg     | in  | i_cfg_we               | i_cfg_idx, i_cfg_data
//
// One byte per cycle sustained while no result waits on i_m_tready; o_m_tvalid is registered
// and rises once the last byte has passed from the input register through the checker.
// The byte-wide CRC step and the length/CRC compares sit between the input and result
// registers. Synchronous active-low reset clears the stream state and both valid flags.
// A result waiting on i_m_tready holds a filled input register and the checker until taken.
`default_nettype none
module crc32_framed_blob_validator_core
    import cfbv_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [7:0]        i_s_tdata,   // [7:0] data_byte
    input  wire logic              i_s_tlast,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [OUT_W-1:0]       o_m_tdata,   // [1:0] status, [17:2] entry_count
    input  wire logic              i_cfg_we,
    input  wire t_reg_idx          i_cfg_idx,
    input  wire logic [CFG_W-1:0]  i_cfg_data
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        r_out_valid;
    t_result     r_out_result;
    logic [31:0] r_magic;
    logic [15:0] r_version;
    logic        w_advance;
    logic        w_proc;
    t_result     w_result;

    assign w_advance  = !r_out_valid || i_m_tready;
    assign w_proc     = r_in_valid && w_advance;
    assign o_s_tready = !r_in_valid || w_advance;

    cfbv_frame_chk u_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_proc),
        .i_byte    (r_in_byte),
        .i_last    (r_in_last),
        .i_magic   (r_magic),
        .i_version (r_version),
        .o_result  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_magic     <= '0;
            r_version   <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_advance) begin
                r_out_valid <= w_proc && r_in_last;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MAGIC:   r_magic   <= i_cfg_data[31:0];
                    REG_VERSION: r_version <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
        if (w_proc && r_in_last) begin
            r_out_result <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out_result.entry_count, r_out_result.status};

`ifndef SYNTHESIS
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_in_valid && r_out_valid && !i_m_tready))
        else $error("input stalled without a blocked result");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(w_proc && r_in_last))
        else $error("result raised without a processed last byte");
`endif

endmodule
`default_nettype wire

FILE: sim/tb_crc32_framed_blob_validator_core.sv
// Testbench for the framed blob CRC-32 validator: directed and random blobs, self-checking.
`timescale 1ns / 100ps
module tb_crc32_framed_blob_validator_core;
    import cfbv_pkg::*;

    localparam int PIPE_SLACK = 6;
    localparam int WDOG_LIMIT = 4000;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_s_tvalid;
    logic              o_s_tready;
    logic [7:0]        i_s_tdata;   // [7:0] data_byte
    logic              i_s_tlast;
    logic              o_m_tvalid;
    logic              i_m_tready;
    logic [OUT_W-1:0]  o_m_tdata;   // [1:0] status, [17:2] entry_count
    logic              i_cfg_we;
    t_reg_idx          i_cfg_idx;
    logic [CFG_W-1:0]  i_cfg_data;

    crc32_framed_blob_validator_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // validator state as seen from outside
    logic [31:0]        cfg_magic;
    logic [15:0]        cfg_version;
    logic [CNT_W-1:0]   seen_bytes;
    logic [31:0]        run_crc;
    logic [31:0]        tail_win;
    logic [63:0]        hdr_bytes;

    t_result            verdicts[$];
    logic [7:0]         blob_q[$];
    int                 mismatches = 0;
    int                 src_gap_pct = 0;
    int                 sink_stall_pct = 0;
    int                 quiet_cycles = 0;

    function automatic logic [31:0] crc_step8(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    task automatic clear_stream();
        seen_bytes = '0;
        run_crc    = CRC_INIT;
        tail_win   = '0;
        hdr_bytes  = '0;
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic last);
        t_result     r;
        int unsigned want_len;
        if (seen_bytes < HEADER_BYTES) hdr_bytes[8*seen_bytes +: 8] = b;
        if (seen_bytes >= TAIL_BYTES) run_crc = crc_step8(run_crc, tail_win[7:0]);
        tail_win = {b, tail_win[31:8]};
        if (seen_bytes != CNT_MAX) seen_bytes = seen_bytes + 1'b1;
        if (last) begin
            want_len = HEADER_BYTES + TAIL_BYTES + int'(hdr_bytes[63:48]) * ITEM_BYTES;
            r.entry_count = hdr_bytes[63:48];
            if (seen_bytes < MIN_BYTES)
                r.status = ST_SHORT;
            else if (hdr_bytes[31:0] != cfg_magic || hdr_bytes[47:32] != cfg_version)
                r.status = ST_CORRUPT;
            else if (seen_bytes == CNT_MAX || seen_bytes != want_len)
                r.status = ST_CORRUPT;
            else if (~run_crc != tail_win)
                r.status = ST_CRC;
            else
                r.status = ST_OK;
            verdicts.push_back(r);
            clear_stream();
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got %0h, expected %0h", what, got, want);
        mismatches++;
    endtask

    // sender: called and returns at a falling edge, tvalid left high
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < src_gap_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        predict_byte(b, last);
        @(negedge i_clk);
    endtask

    task automatic hold_until_drained();
        i_s_tvalid <= 1'b0;
        while (verdicts.size() != 0) @(negedge i_clk);
        repeat (PIPE_SLACK) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        hold_until_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        if (idx == REG_MAGIC) cfg_magic = val;
        else cfg_version = val[15:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic build_blob(input logic [31:0] magic, input logic [15:0] ver,
                              input logic [15:0] cnt, input int body_bytes,
                              input bit crc_good);
        logic [31:0] c;
        blob_q.delete();
        for (int i = 0; i < 4; i++) blob_q.push_back(magic[8*i +: 8]);
        for (int i = 0; i < 2; i++) blob_q.push_back(ver[8*i +: 8]);
        for (int i = 0; i < 2; i++) blob_q.push_back(cnt[8*i +: 8]);
        repeat (body_bytes) blob_q.push_back(8'($urandom_range(255)));
        c = CRC_INIT;
        foreach (blob_q[i]) c = crc_step8(c, blob_q[i]);
        c = ~c;
        if (!crc_good) c = c ^ (32'd1 << $urandom_range(31));
        for (int i = 0; i < 4; i++) blob_q.push_back(c[8*i +: 8]);
    endtask

    task automatic build_raw(input int n);
        blob_q.delete();
        repeat (n) blob_q.push_back(8'($urandom_range(255)));
    endtask

    task automatic send_blob();
        foreach (blob_q[i]) begin
            if (i > 0 && $urandom_range(199) == 0) hold_until_drained();
            send_byte(blob_q[i], i == blob_q.size() - 1);
        end
    endtask

    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (verdicts.size() == 0) begin
                report_mismatch("unexpected result", o_m_tdata, 0);
            end else begin
                want = verdicts.pop_front();
                if (o_m_tdata[1:0] != want.status)
                    report_mismatch("status", o_m_tdata[1:0], want.status);
                if (o_m_tdata[17:2] != want.entry_count)
                    report_mismatch("entry_count", o_m_tdata[17:2], want.entry_count);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // registers at reset value, minimal and maximal entry counts
    task automatic test_reset_config();
        build_blob(32'd0, 16'd0, 16'd0, 0, 1'b1);
        send_blob();
        build_blob(32'd0, 16'd0, 16'hFFFF, 0, 1'b1);
        send_blob();
    endtask

    task automatic test_short_blobs();
        build_raw(1);
        send_blob();
        build_raw(7);
        send_blob();
        build_raw(11);
        send_blob();
    endtask

    task automatic test_header_checks();
        logic [31:0] m;
        logic [15:0] v;
        m = $urandom;
        v = $urandom_range(16'hFFFF);
        write_reg(REG_MAGIC, m);
        write_reg(REG_VERSION, {16'd0, v});
        build_blob(m, v, 16'd1, 20, 1'b1);
        send_blob();
        build_blob(~m, v, 16'd1, 20, 1'b1);
        send_blob();
        build_blob(m, v ^ 16'h8000, 16'd1, 20, 1'b1);
        send_blob();
        build_blob(m, v, 16'd1, 21, 1'b1);
        send_blob();
        build_blob(m, v, 16'd1, 19, 1'b1);
        send_blob();
        build_blob(m, v, 16'd2, 40, 1'b0);
        send_blob();
    endtask

    task automatic random_blob(input logic [31:0] m, input logic [15:0] v);
        int          kind;
        logic [15:0] cnt;
        kind = $urandom_range(99);
        cnt  = ($urandom_range(9) == 0) ? 16'($urandom_range(4, 2)) :
                                          16'($urandom_range(99) < 65 ? 0 : 1);
        if (kind < 55)
            build_blob(m, v, cnt, cnt * ITEM_BYTES, 1'b1);
        else if (kind < 63)
            build_blob(m ^ (32'd1 << $urandom_range(31)), v, cnt, cnt * ITEM_BYTES, 1'b1);
        else if (kind < 70)
            build_blob(m, v ^ (16'd1 << $urandom_range(15)), cnt, cnt * ITEM_BYTES, 1'b1);
        else if (kind < 74)
            build_blob(m, v, 16'($urandom), $urandom_range(30), 1'b1);
        else if (kind < 78)
            build_blob(m, v, 16'd1, $urandom_range(1) ? $urandom_range(19, 17)
                                                      : $urandom_range(23, 21), 1'b1);
        else if (kind < 88)
            build_blob(m, v, cnt, cnt * ITEM_BYTES, 1'b0);
        else if (kind < 94)
            build_raw($urandom_range(11, 1));
        else
            build_raw($urandom_range(40, 1));
    endtask

    task automatic test_random_blobs();
        logic [31:0] m;
        logic [15:0] v;
        int          phase_bytes;
        int          n_blobs;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    m = '1;
                    v = '1;
                end
                2: begin
                    m = '0;
                    v = '0;
                end
                default: begin
                    m = $urandom;
                    v = $urandom_range(16'hFFFF);
                end
            endcase
            write_reg(REG_MAGIC, m);
            write_reg(REG_VERSION, {16'd0, v});
            src_gap_pct    = (ph == 1) ? 48 : (ph == 3) ? 30 : 0;
            sink_stall_pct = (ph == 2) ? 48 : (ph == 3) ? 30 : 0;
            phase_bytes = 0;
            n_blobs     = 0;
            while (phase_bytes < 40 || n_blobs < 3) begin
                random_blob(m, v);
                phase_bytes += blob_q.size();
                n_blobs++;
                send_blob();
            end
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tlast  <= 1'b0;
        i_m_tready <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= REG_MAGIC;
        i_cfg_data <= '0;
        cfg_magic   = '0;
        cfg_version = '0;
        clear_stream();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_config();
        test_short_blobs();
        test_header_checks();
        test_random_blobs();

        hold_until_drained();
        repeat (PIPE_SLACK) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
